### sv/perceptron_branch_predictor_top_macros.svh
// ----------------------------------------------------------------------------
// Perceptron branch predictor assertion macros
// Shared property wrappers clocked on aclk and disabled while in reset.
// ----------------------------------------------------------------------------
`ifndef PERCEPTRON_BRANCH_PREDICTOR_TOP_MACROS_SVH
`define PERCEPTRON_BRANCH_PREDICTOR_TOP_MACROS_SVH

// Same-cycle implication.
`define PBP_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("perceptron predictor check failed");

// Next-cycle implication.
`define PBP_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("perceptron predictor check failed");

`endif

### sv/pbp_pkg.sv
// ----------------------------------------------------------------------------
// Perceptron branch predictor package
// Shared constants, operation codes and status types.
// ----------------------------------------------------------------------------
package pbp_pkg;

    // Default geometry of the weight table.
    localparam int DEF_INDEX_BITS  = 8;
    localparam int DEF_HIST_LEN    = 16;
    localparam int DEF_WEIGHT_BITS = 8;

    // Fixed field widths.
    localparam int PC_W      = 32;
    localparam int THRESH_W  = 8;
    localparam int SUM_OUT_W = 13;

    // Stream payload layout.
    localparam int S_TDATA_W   = 40;
    localparam int S_OUTCOME_B = 32;
    localparam int M_TDATA_W   = 16;

    localparam logic [THRESH_W-1:0] THRESH_RESET = 8'd29;

    // Operation carried in s_tuser.
    typedef enum logic {
        PBP_OP_PREDICT = 1'b0,
        PBP_OP_TRAIN   = 1'b1
    } pbp_op_t;

    // Status handed from the update datapath to the control logic.
    typedef struct packed {
        logic prediction;
        logic train;
        logic changed;
    } pbp_status_t;

endpackage

### sv/pbp_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module pbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // A read of the address being written returns the old contents.
    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### sv/pbp_row_update.sv
// ----------------------------------------------------------------------------
// Perceptron row datapath
// Dot product of one weight row with the history, training decision and the
// saturating weight update.
// ----------------------------------------------------------------------------
module pbp_row_update #(
    parameter int HIST_LEN    = pbp_pkg::DEF_HIST_LEN,
    parameter int WEIGHT_BITS = pbp_pkg::DEF_WEIGHT_BITS
) (
    input  logic [(HIST_LEN+1)*WEIGHT_BITS-1:0] row_in,
    input  logic [HIST_LEN-1:0]                 history,
    input  pbp_pkg::pbp_op_t                    op,
    input  logic                                outcome,
    input  logic [pbp_pkg::THRESH_W-1:0]        threshold,
    output logic [(HIST_LEN+1)*WEIGHT_BITS-1:0] row_out,
    output logic signed [pbp_pkg::SUM_OUT_W-1:0] sum_out,
    output pbp_pkg::pbp_status_t                status
);

    localparam int ROW_LEN = HIST_LEN + 1;
    localparam int SUM_W   = WEIGHT_BITS + $clog2(ROW_LEN) + 1;
    localparam int ACC_W   = (SUM_W > pbp_pkg::SUM_OUT_W) ? SUM_W : pbp_pkg::SUM_OUT_W;
    localparam int LEAVES  = 1 << $clog2(ROW_LEN);
    localparam logic signed [WEIGHT_BITS-1:0] W_MAX = {1'b0, {(WEIGHT_BITS-1){1'b1}}};
    localparam logic signed [WEIGHT_BITS-1:0] W_MIN = {1'b1, {(WEIGHT_BITS-1){1'b0}}};

    logic signed [ACC_W-1:0] node [2*LEAVES];
    logic signed [ACC_W-1:0] sum;
    logic        [ACC_W-1:0] mag;
    logic                    pred;
    logic                    train;
    logic [ROW_LEN-1:0]      moved;

    // Leaves of the adder tree: bias, then signed history terms, then zeros.
    genvar gi;
    generate
        for (gi = 0; gi < LEAVES; gi++) begin : g_leaf
            if (gi == 0) begin : g_bias
                assign node[LEAVES] = {{(ACC_W-WEIGHT_BITS){row_in[WEIGHT_BITS-1]}},
                                       row_in[WEIGHT_BITS-1:0]};
            end else if (gi < ROW_LEN) begin : g_term
                logic signed [ACC_W-1:0] w_ext;
                assign w_ext = {{(ACC_W-WEIGHT_BITS){row_in[gi*WEIGHT_BITS+WEIGHT_BITS-1]}},
                                row_in[gi*WEIGHT_BITS +: WEIGHT_BITS]};
                assign node[LEAVES+gi] = history[gi-1] ? w_ext : -w_ext;
            end else begin : g_pad
                assign node[LEAVES+gi] = '0;
            end
        end

        // Balanced adder tree toward the root node.
        for (gi = 1; gi < LEAVES; gi++) begin : g_tree
            assign node[gi] = node[2*gi] + node[2*gi+1];
        end
    endgenerate

    assign node[0] = '0;
    assign sum     = node[1];
    assign sum_out = sum[pbp_pkg::SUM_OUT_W-1:0];

    // Prediction and training decision.
    always_comb begin
        pred  = !sum[ACC_W-1] && (sum != '0);
        mag   = sum[ACC_W-1] ? -sum : sum;
        train = (op == pbp_pkg::PBP_OP_TRAIN) &&
                ((pred != outcome) ||
                 (mag <= {{(ACC_W-pbp_pkg::THRESH_W){1'b0}}, threshold}));
    end

    // Saturating one-step move of each weight toward the training target.
    generate
        for (gi = 0; gi < ROW_LEN; gi++) begin : g_upd
            logic signed [WEIGHT_BITS-1:0] w;
            logic                          up;
            logic                          held;
            assign w    = row_in[gi*WEIGHT_BITS +: WEIGHT_BITS];
            assign up   = (gi == 0) ? outcome : (history[(gi == 0) ? 0 : gi-1] == outcome);
            assign held = up ? (w == W_MAX) : (w == W_MIN);
            assign moved[gi] = train && !held;
            assign row_out[gi*WEIGHT_BITS +: WEIGHT_BITS] =
                !moved[gi] ? w : (up ? w + WEIGHT_BITS'(1) : w - WEIGHT_BITS'(1));
        end
    endgenerate

    assign status.prediction = pred;
    assign status.train      = train;
    assign status.changed    = |moved;

endmodule

### sv/perceptron_branch_predictor_top.sv
// ----------------------------------------------------------------------------
// Perceptron branch predictor
// Streaming predictor with a weight table RAM, global history and training.
// ----------------------------------------------------------------------------
// Usage: each input transaction carries an operation in s_tuser (predict or
// train) and the branch pc and resolved outcome in s_tdata. Every input
// transaction yields exactly one result transaction on the m_ side with the
// prediction, the signed perceptron sum before any update and a flag telling
// whether a train changed the selected row.
// Each accepted transaction goes through the compute stage register, then
// the output register that drives m_tvalid. One transaction is taken every
// cycle unless the receiver stalls: the row is read from the single table
// RAM at the accept edge, written back if the transaction trains, and a
// forwarding register covers back-to-back transactions to the same row.
// Reset (aresetn low, synchronous) clears the history, sets the training
// threshold to 29 and marks every row invalid, so an unwritten row reads as
// all weights equal to one; no clearing sweep is needed.
// When the receiver stalls, the result stays in the output register and the
// input side stops accepting once the compute stage is also full.
// The threshold register may be written with cfg_wr_en whenever the block
// has no transaction in flight.
// ----------------------------------------------------------------------------
`include "perceptron_branch_predictor_top_macros.svh"

module perceptron_branch_predictor_top #(
    parameter int INDEX_BITS  = pbp_pkg::DEF_INDEX_BITS,
    parameter int HIST_LEN    = pbp_pkg::DEF_HIST_LEN,
    parameter int WEIGHT_BITS = pbp_pkg::DEF_WEIGHT_BITS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Configuration: training threshold
    input  logic                          cfg_wr_en,
    input  logic [pbp_pkg::THRESH_W-1:0]  cfg_wr_data,
    // Input stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [pbp_pkg::S_TDATA_W-1:0] s_tdata,  // [31:0] pc, [32] outcome, rest zero
    input  logic                          s_tuser,  // [0] op
    // Result stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [pbp_pkg::M_TDATA_W-1:0] m_tdata   // [0] prediction, [13:1] perceptron_sum,
                                                    // [14] weights_updated, [15] zero
);

    localparam int ROWS    = 1 << INDEX_BITS;
    localparam int ROW_LEN = HIST_LEN + 1;
    localparam int ROW_W   = ROW_LEN * WEIGHT_BITS;
    localparam logic [ROW_W-1:0] ROW_ONES = {ROW_LEN{WEIGHT_BITS'(1)}};

    // Configuration register.
    logic [pbp_pkg::THRESH_W-1:0] threshold_reg;

    // Compute stage.
    logic                  s1_valid_reg;
    pbp_pkg::pbp_op_t      s1_op_reg;
    logic [INDEX_BITS-1:0] s1_idx_reg;
    logic                  s1_outcome_reg;
    logic                  s1_row_valid_reg;
    logic                  bypass_hit_reg;
    logic [ROW_W-1:0]      bypass_row_reg;
    logic [HIST_LEN-1:0]   hist_reg;
    logic [HIST_LEN-1:0]   hist_next;
    logic [ROWS-1:0]       row_valid_reg;

    // Output register.
    logic                                 m_valid_reg;
    logic                                 m_pred_reg;
    logic signed [pbp_pkg::SUM_OUT_W-1:0] m_sum_reg;
    logic                                 m_updated_reg;

    logic                                 s_accept;
    logic                                 s1_adv;
    logic [INDEX_BITS-1:0]                s_idx;
    logic [ROW_W-1:0]                     rd_row;
    logic [ROW_W-1:0]                     cur_row;
    logic [ROW_W-1:0]                     new_row;
    logic signed [pbp_pkg::SUM_OUT_W-1:0] sum;
    pbp_pkg::pbp_status_t                 status;
    logic                                 wr_en;

    // Handshake and stage advance.
    assign s1_adv   = s1_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || s1_adv;
    assign s_accept = s_tvalid && s_tready;
    assign s_idx    = s_tdata[INDEX_BITS-1:0];
    assign wr_en    = s1_adv && status.train;

    // Weight table.
    pbp_ram #(
        .WIDTH (ROW_W),
        .DEPTH (ROWS)
    ) u_table (
        .clk     (aclk),
        .wr_en   (wr_en),
        .wr_addr (s1_idx_reg),
        .wr_data (new_row),
        .rd_en   (s_accept),
        .rd_addr (s_idx),
        .rd_data (rd_row)
    );

    // Row source: forwarded write, stored row, or the reset row.
    always_comb begin
        if (bypass_hit_reg) begin
            cur_row = bypass_row_reg;
        end else if (s1_row_valid_reg) begin
            cur_row = rd_row;
        end else begin
            cur_row = ROW_ONES;
        end
    end

    pbp_row_update #(
        .HIST_LEN    (HIST_LEN),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_update (
        .row_in    (cur_row),
        .history   (hist_reg),
        .op        (s1_op_reg),
        .outcome   (s1_outcome_reg),
        .threshold (threshold_reg),
        .row_out   (new_row),
        .sum_out   (sum),
        .status    (status)
    );

    // History shifts in the outcome of every train transaction.
    assign hist_next = HIST_LEN'({hist_reg, s1_outcome_reg});

    // Configuration register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg <= pbp_pkg::THRESH_RESET;
        end else if (cfg_wr_en) begin
            threshold_reg <= cfg_wr_data;
        end
    end

    // Compute stage control, history and row valid bits.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg   <= 1'b0;
            bypass_hit_reg <= 1'b0;
            hist_reg       <= '0;
            row_valid_reg  <= '0;
        end else begin
            if (s_accept) begin
                s1_valid_reg   <= 1'b1;
                bypass_hit_reg <= wr_en && (s1_idx_reg == s_idx);
            end else if (s1_adv) begin
                s1_valid_reg   <= 1'b0;
                bypass_hit_reg <= 1'b0;
            end
            if (s1_adv && (s1_op_reg == pbp_pkg::PBP_OP_TRAIN)) begin
                hist_reg <= hist_next;
            end
            if (wr_en) begin
                row_valid_reg[s1_idx_reg] <= 1'b1;
            end
        end
    end

    // Compute stage payload.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_op_reg        <= pbp_pkg::pbp_op_t'(s_tuser);
            s1_idx_reg       <= s_idx;
            s1_outcome_reg   <= s_tdata[pbp_pkg::S_OUTCOME_B];
            s1_row_valid_reg <= row_valid_reg[s_idx];
            bypass_row_reg   <= new_row;
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s1_adv) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_adv) begin
            m_pred_reg    <= status.prediction;
            m_sum_reg     <= sum;
            m_updated_reg <= status.changed;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, m_updated_reg, m_sum_reg, m_pred_reg};

    // Checks.
    `PBP_ASSERT_IMP(a_predict_no_change,
        s1_adv && (s1_op_reg == pbp_pkg::PBP_OP_PREDICT), !status.changed && !status.train)
    `PBP_ASSERT_NXT(a_hist_stable,
        !(s1_adv && (s1_op_reg == pbp_pkg::PBP_OP_TRAIN)), $stable(hist_reg))
    `PBP_ASSERT_IMP(a_bypass_needs_stage, bypass_hit_reg, s1_valid_reg)
    `PBP_ASSERT_IMP(a_result_from_stage, $rose(m_valid_reg), $past(s1_adv))

endmodule
